// ===== hdl/ucdc_pkg.sv =====
// Package for the Unix time / civil date converter: item types, commands,
// calendar constants, reciprocal multipliers and the month offset table.
// No dependencies.
package ucdc_pkg;

  localparam logic CMD_SPLIT = 1'b0;
  localparam logic CMD_MAKE  = 1'b1;

  typedef struct packed {
    logic        command;
    logic [37:0] unix_seconds;
    logic [13:0] year_in;
    logic [3:0]  month_in;
    logic [4:0]  day_in;
    logic [4:0]  hour_in;
    logic [5:0]  minute_in;
    logic [5:0]  second_in;
  } ucdc_in_t;

  typedef struct packed {
    logic [37:0] seconds_out;
    logic [13:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic [2:0]  weekday_out;
  } ucdc_out_t;

  localparam int unsigned EPOCH_DAYS   = 719468;
  localparam int unsigned ERA_DAYS     = 146097;
  localparam int unsigned ERA_LAST     = 146096;
  localparam int unsigned CENT_DAYS    = 36524;
  localparam int unsigned QUAD_DAYS    = 1460;
  localparam int unsigned YEAR_DAYS    = 365;
  localparam int unsigned ERA_YEARS    = 400;
  localparam int unsigned CENT_YEARS   = 100;
  localparam int unsigned SEC_PER_DAY  = 86400;
  localparam int unsigned SEC_PER_HOUR = 3600;
  localparam int unsigned SEC_PER_MIN  = 60;
  localparam int unsigned WEEK_DAYS    = 7;
  localparam int unsigned EPOCH_WDAY   = 4;
  localparam int unsigned MONTH_SPAN   = 153;
  localparam int unsigned MP_SCALE     = 5;
  localparam int unsigned MP_BIAS      = 2;

  // seconds / 86400 = (seconds >> DAY_PRE) / DAY_ODD
  localparam int unsigned DAY_PRE = 7;
  localparam int unsigned DAY_ODD = SEC_PER_DAY / 128;

  // floor(x / d) = (x * ceil(2^sh / d)) >> sh, exact for x below 2^(sh - clog2(d))
  localparam int unsigned DAY_SH  = 41;
  localparam int unsigned ERA_SH  = 40;
  localparam int unsigned WK_SH   = 25;
  localparam int unsigned HR_SH   = 29;
  localparam int unsigned QUAD_SH = 29;
  localparam int unsigned CENT_SH = 34;
  localparam int unsigned LAST_SH = 36;
  localparam int unsigned YR_SH   = 27;
  localparam int unsigned MIN_SH  = 18;
  localparam int unsigned C100_SH = 16;
  localparam int unsigned MP_SH   = 19;
  localparam int unsigned Y400_SH = 23;

  localparam logic [31:0] DAY_RCP =
    32'(((64'd1 << DAY_SH) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));
  localparam logic [22:0] ERA_RCP =
    23'(((64'd1 << ERA_SH) + 64'(ERA_DAYS) - 64'd1) / 64'(ERA_DAYS));
  localparam logic [22:0] WK_RCP =
    23'(((64'd1 << WK_SH) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));
  localparam logic [17:0] HR_RCP =
    18'(((64'd1 << HR_SH) + 64'(SEC_PER_HOUR) - 64'd1) / 64'(SEC_PER_HOUR));
  localparam logic [18:0] QUAD_RCP =
    19'(((64'd1 << QUAD_SH) + 64'(QUAD_DAYS) - 64'd1) / 64'(QUAD_DAYS));
  localparam logic [18:0] CENT_RCP =
    19'(((64'd1 << CENT_SH) + 64'(CENT_DAYS) - 64'd1) / 64'(CENT_DAYS));
  localparam logic [18:0] LAST_RCP =
    19'(((64'd1 << LAST_SH) + 64'(ERA_LAST) - 64'd1) / 64'(ERA_LAST));
  localparam logic [18:0] YR_RCP =
    19'(((64'd1 << YR_SH) + 64'(YEAR_DAYS) - 64'd1) / 64'(YEAR_DAYS));
  localparam logic [12:0] MIN_RCP =
    13'(((64'd1 << MIN_SH) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));
  localparam logic [9:0] C100_RCP =
    10'(((64'd1 << C100_SH) + 64'(CENT_YEARS) - 64'd1) / 64'(CENT_YEARS));
  localparam logic [11:0] MP_RCP =
    12'(((64'd1 << MP_SH) + 64'(MONTH_SPAN) - 64'd1) / 64'(MONTH_SPAN));
  localparam logic [14:0] Y400_RCP =
    15'(((64'd1 << Y400_SH) + 64'(ERA_YEARS) - 64'd1) / 64'(ERA_YEARS));

  // days before month mp of a March-based year: (153 * mp + 2) / 5
  function automatic logic [8:0] month_base(input logic [3:0] mp);
    logic [8:0] base;
    case (mp)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd61;
      4'd3:    base = 9'd92;
      4'd4:    base = 9'd122;
      4'd5:    base = 9'd153;
      4'd6:    base = 9'd184;
      4'd7:    base = 9'd214;
      4'd8:    base = 9'd245;
      4'd9:    base = 9'd275;
      4'd10:   base = 9'd306;
      4'd11:   base = 9'd337;
      4'd12:   base = 9'd367;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

endpackage

// ===== hdl/unix_time_civil_date_convert.sv =====
// Unix seconds to civil date and back, eight register stages.
// Depends on ucdc_pkg for item types, constants and the month table.
//
//   port group   dir   handshake           payload
//   in_          in    in_valid/in_stall   ucdc_in_t  (command and both field sets)
//   out_         out   out_valid/out_stall ucdc_out_t (unused mode fields zero)
//
// One item per cycle while in_stall is low; each item passes through the stages in order.
// The depth is set by the chain of reciprocal multiplies in split mode.
// Reset clears the stage valid bits only; payload registers are not reset.
// A stalled output holds the last stage; earlier stages keep moving into
// empty slots, so bubbles close up before the input stalls.
module unix_time_civil_date_convert
  import ucdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  ucdc_in_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output ucdc_out_t out_item
);

  logic [8:1] vld_r;
  logic [8:1] vld_nxt;
  logic [8:1] adv;
  logic [7:1] cmd_r;

  // stage control
  assign adv[8] = !vld_r[8] || !out_stall;
  assign adv[7] = !vld_r[7] || adv[8];
  assign adv[6] = !vld_r[6] || adv[7];
  assign adv[5] = !vld_r[5] || adv[6];
  assign adv[4] = !vld_r[4] || adv[5];
  assign adv[3] = !vld_r[3] || adv[4];
  assign adv[2] = !vld_r[2] || adv[3];
  assign adv[1] = !vld_r[1] || adv[2];
  assign in_stall  = !adv[1];
  assign out_valid = vld_r[8];

  always_comb begin
    vld_nxt = vld_r;
    if (adv[1]) vld_nxt[1] = in_valid;
    if (adv[2]) vld_nxt[2] = vld_r[1];
    if (adv[3]) vld_nxt[3] = vld_r[2];
    if (adv[4]) vld_nxt[4] = vld_r[3];
    if (adv[5]) vld_nxt[5] = vld_r[4];
    if (adv[6]) vld_nxt[6] = vld_r[5];
    if (adv[7]) vld_nxt[7] = vld_r[6];
    if (adv[8]) vld_nxt[8] = vld_r[7];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // ---------------- stage 1 ----------------
  logic [62:0] day_prod;
  logic        mk_early;
  logic [13:0] mk_yp;
  logic        mk_neg;
  logic [28:0] y400_prod;
  logic [3:0]  mk_mp;
  logic [9:0]  mk_doy;

  logic [21:0] s1_days_r;
  logic [16:0] s1_ulo_r;
  logic [13:0] m1_yp_r;
  logic        m1_neg_r;
  logic [5:0]  m1_era_r;
  logic [9:0]  m1_doy_r;
  logic [4:0]  m1_hour_r;
  logic [5:0]  m1_min_r;
  logic [5:0]  m1_sec_r;

  assign day_prod  = 63'(in_item.unix_seconds[37:DAY_PRE]) * 63'(DAY_RCP);
  assign mk_early  = (in_item.month_in <= 4'd2);
  assign mk_yp     = in_item.year_in - 14'(mk_early);
  assign mk_neg    = (in_item.year_in == '0) && mk_early;
  assign y400_prod = 29'(mk_yp) * 29'(Y400_RCP);
  assign mk_mp     = mk_early ? in_item.month_in + 4'd9 : in_item.month_in - 4'd3;
  assign mk_doy    = 10'(month_base(mk_mp)) + 10'(in_item.day_in) - 10'd1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      cmd_r[1]  <= in_item.command;
      s1_days_r <= day_prod[62:DAY_SH];
      s1_ulo_r  <= in_item.unix_seconds[16:0];
      m1_yp_r   <= mk_yp;
      m1_neg_r  <= mk_neg;
      m1_era_r  <= y400_prod[28:Y400_SH];
      m1_doy_r  <= mk_doy;
      m1_hour_r <= in_item.hour_in;
      m1_min_r  <= in_item.minute_in;
      m1_sec_r  <= in_item.second_in;
    end
  end

  // ---------------- stage 2 ----------------
  logic [38:0] s2_dsec;
  logic [21:0] s2_z;
  logic [44:0] era_prod;
  logic [21:0] s2_x7;
  logic [44:0] wk_prod;
  logic [13:0] m2_era_yrs;
  logic [16:0] m2_hms;

  logic [16:0] s2_rem_r;
  logic [21:0] s2_z_r;
  logic [4:0]  s2_era_r;
  logic [2:0]  s2_x7lo_r;
  logic [2:0]  s2_q7lo_r;
  logic [6:0]  m2_era_r;
  logic [8:0]  m2_yoe_r;
  logic [9:0]  m2_doy_r;
  logic [16:0] m2_hms_r;

  assign s2_dsec    = 39'(s1_days_r) * 39'(SEC_PER_DAY);
  assign s2_z       = s1_days_r + 22'(EPOCH_DAYS);
  assign era_prod   = 45'(s2_z) * 45'(ERA_RCP);
  assign s2_x7      = s1_days_r + 22'(EPOCH_WDAY);
  assign wk_prod    = 45'(s2_x7) * 45'(WK_RCP);
  assign m2_era_yrs = 14'(m1_era_r) * 14'(ERA_YEARS);
  assign m2_hms     = 17'(m1_hour_r) * 17'(SEC_PER_HOUR)
                    + 17'(m1_min_r) * 17'(SEC_PER_MIN) + 17'(m1_sec_r);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      cmd_r[2]  <= cmd_r[1];
      s2_rem_r  <= s1_ulo_r - s2_dsec[16:0];
      s2_z_r    <= s2_z;
      s2_era_r  <= era_prod[44:ERA_SH];
      s2_x7lo_r <= s2_x7[2:0];
      s2_q7lo_r <= wk_prod[WK_SH+2:WK_SH];
      m2_era_r  <= m1_neg_r ? '1 : {1'b0, m1_era_r};
      m2_yoe_r  <= m1_neg_r ? 9'(ERA_YEARS - 1) : 9'(m1_yp_r - m2_era_yrs);
      m2_doy_r  <= m1_doy_r;
      m2_hms_r  <= m2_hms;
    end
  end

  // ---------------- stage 3 ----------------
  logic [21:0] s3_era_days;
  logic [34:0] hour_prod;
  logic [18:0] mc100_prod;
  logic [18:0] m3_doe;

  logic [17:0] s3_doe_r;
  logic [16:0] s3_rem_r;
  logic [4:0]  s3_era_r;
  logic [4:0]  s3_hour_r;
  logic [2:0]  s3_wd_r;
  logic [6:0]  m3_era_r;
  logic [18:0] m3_doe_r;
  logic [16:0] m3_hms_r;

  assign s3_era_days = 22'(s2_era_r) * 22'(ERA_DAYS);
  assign hour_prod   = 35'(s2_rem_r) * 35'(HR_RCP);
  assign mc100_prod  = 19'(m2_yoe_r) * 19'(C100_RCP);
  assign m3_doe      = 19'(m2_yoe_r) * 19'(YEAR_DAYS) + 19'(m2_yoe_r[8:2])
                     - 19'(mc100_prod[18:C100_SH]) + {{9{m2_doy_r[9]}}, m2_doy_r};

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      cmd_r[3]  <= cmd_r[2];
      s3_doe_r  <= 18'(s2_z_r - s3_era_days);
      s3_rem_r  <= s2_rem_r;
      s3_era_r  <= s2_era_r;
      s3_hour_r <= hour_prod[HR_SH+4:HR_SH];
      s3_wd_r   <= s2_x7lo_r - 3'(s2_q7lo_r * 3'(WEEK_DAYS));
      m3_era_r  <= m2_era_r;
      m3_doe_r  <= m3_doe;
      m3_hms_r  <= m2_hms_r;
    end
  end

  // ---------------- stage 4 ----------------
  logic [36:0] quad_prod;
  logic [36:0] cent_prod;
  logic [36:0] last_prod;
  logic [16:0] s4_hr_secs;
  logic [23:0] m4_era_x;
  logic [23:0] m4_days;

  logic [17:0] s4_doe_r;
  logic [7:0]  s4_a_r;
  logic [2:0]  s4_b_r;
  logic        s4_c_r;
  logic [4:0]  s4_era_r;
  logic [4:0]  s4_hour_r;
  logic [11:0] s4_rh_r;
  logic [2:0]  s4_wd_r;
  logic [23:0] m4_days_r;
  logic [16:0] m4_hms_r;

  assign quad_prod  = 37'(s3_doe_r) * 37'(QUAD_RCP);
  assign cent_prod  = 37'(s3_doe_r) * 37'(CENT_RCP);
  assign last_prod  = 37'(s3_doe_r) * 37'(LAST_RCP);
  assign s4_hr_secs = 17'(s3_hour_r) * 17'(SEC_PER_HOUR);
  assign m4_era_x   = {{17{m3_era_r[6]}}, m3_era_r};
  assign m4_days    = m4_era_x * 24'(ERA_DAYS) + {{5{m3_doe_r[18]}}, m3_doe_r}
                    - 24'(EPOCH_DAYS);

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      cmd_r[4]  <= cmd_r[3];
      s4_doe_r  <= s3_doe_r;
      s4_a_r    <= quad_prod[36:QUAD_SH];
      s4_b_r    <= cent_prod[36:CENT_SH];
      s4_c_r    <= last_prod[LAST_SH];
      s4_era_r  <= s3_era_r;
      s4_hour_r <= s3_hour_r;
      s4_rh_r   <= 12'(s3_rem_r - s4_hr_secs);
      s4_wd_r   <= s3_wd_r;
      m4_days_r <= m4_days;
      m4_hms_r  <= m3_hms_r;
    end
  end

  // ---------------- stage 5 ----------------
  logic [17:0] s5_t;
  logic [36:0] yoe_prod;
  logic [24:0] min_prod;
  logic [37:0] m5_dsec;

  logic [17:0] s5_doe_r;
  logic [8:0]  s5_yoe_r;
  logic [4:0]  s5_era_r;
  logic [4:0]  s5_hour_r;
  logic [11:0] s5_rh_r;
  logic [5:0]  s5_min_r;
  logic [2:0]  s5_wd_r;
  logic [37:0] m5_total_r;

  assign s5_t     = s4_doe_r - 18'(s4_a_r) + 18'(s4_b_r) - 18'(s4_c_r);
  assign yoe_prod = 37'(s5_t) * 37'(YR_RCP);
  assign min_prod = 25'(s4_rh_r) * 25'(MIN_RCP);
  assign m5_dsec  = {{14{m4_days_r[23]}}, m4_days_r} * 38'(SEC_PER_DAY);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      cmd_r[5]   <= cmd_r[4];
      s5_doe_r   <= s4_doe_r;
      s5_yoe_r   <= yoe_prod[YR_SH+8:YR_SH];
      s5_era_r   <= s4_era_r;
      s5_hour_r  <= s4_hour_r;
      s5_rh_r    <= s4_rh_r;
      s5_min_r   <= min_prod[MIN_SH+5:MIN_SH];
      s5_wd_r    <= s4_wd_r;
      m5_total_r <= m5_dsec + 38'(m4_hms_r);
    end
  end

  // ---------------- stage 6 ----------------
  logic [18:0] c100_prod;
  logic [17:0] s6_yoe_days;
  logic [11:0] s6_min_secs;

  logic [8:0]  s6_doy_r;
  logic [13:0] s6_yr_r;
  logic [4:0]  s6_hour_r;
  logic [5:0]  s6_min_r;
  logic [5:0]  s6_sec_r;
  logic [2:0]  s6_wd_r;
  logic [37:0] m6_total_r;

  assign c100_prod   = 19'(s5_yoe_r) * 19'(C100_RCP);
  assign s6_yoe_days = 18'(s5_yoe_r) * 18'(YEAR_DAYS) + 18'(s5_yoe_r[8:2])
                     - 18'(c100_prod[18:C100_SH]);
  assign s6_min_secs = 12'(s5_min_r) * 12'(SEC_PER_MIN);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      cmd_r[6]   <= cmd_r[5];
      s6_doy_r   <= 9'(s5_doe_r - s6_yoe_days);
      s6_yr_r    <= 14'(s5_yoe_r) + 14'(s5_era_r) * 14'(ERA_YEARS);
      s6_hour_r  <= s5_hour_r;
      s6_min_r   <= s5_min_r;
      s6_sec_r   <= 6'(s5_rh_r - s6_min_secs);
      s6_wd_r    <= s5_wd_r;
      m6_total_r <= m5_total_r;
    end
  end

  // ---------------- stage 7 ----------------
  logic [10:0] s7_mp_x;
  logic [22:0] mp_prod;

  logic [8:0]  s7_doy_r;
  logic [3:0]  s7_mp_r;
  logic [13:0] s7_yr_r;
  logic [4:0]  s7_hour_r;
  logic [5:0]  s7_min_r;
  logic [5:0]  s7_sec_r;
  logic [2:0]  s7_wd_r;
  logic [37:0] m7_total_r;

  assign s7_mp_x = 11'(s6_doy_r) * 11'(MP_SCALE) + 11'(MP_BIAS);
  assign mp_prod = 23'(s7_mp_x) * 23'(MP_RCP);

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      cmd_r[7]   <= cmd_r[6];
      s7_doy_r   <= s6_doy_r;
      s7_mp_r    <= mp_prod[MP_SH+3:MP_SH];
      s7_yr_r    <= s6_yr_r;
      s7_hour_r  <= s6_hour_r;
      s7_min_r   <= s6_min_r;
      s7_sec_r   <= s6_sec_r;
      s7_wd_r    <= s6_wd_r;
      m7_total_r <= m6_total_r;
    end
  end

  // ---------------- stage 8 ----------------
  logic [3:0] s8_mon;
  ucdc_out_t  out_nxt;
  ucdc_out_t  out_r;

  assign s8_mon = (s7_mp_r < 4'd10) ? s7_mp_r + 4'd3 : s7_mp_r - 4'd9;

  always_comb begin
    out_nxt = '0;
    if (cmd_r[7] == CMD_MAKE) begin
      out_nxt.seconds_out = m7_total_r;
    end else begin
      out_nxt.year_out    = (s8_mon <= 4'd2) ? s7_yr_r + 14'd1 : s7_yr_r;
      out_nxt.month_out   = s8_mon;
      out_nxt.day_out     = 5'(s7_doy_r - month_base(s7_mp_r) + 9'd1);
      out_nxt.hour_out    = s7_hour_r;
      out_nxt.minute_out  = s7_min_r;
      out_nxt.second_out  = s7_sec_r;
      out_nxt.weekday_out = s7_wd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      out_r <= out_nxt;
    end
  end

  assign out_item = out_r;

endmodule

// ===== hdl/ucdc_checker.sv =====
// Port-level checks for unix_time_civil_date_convert, bound to the top level.
// Depends on ucdc_pkg for the item types.
module ucdc_checker
  import ucdc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_stall,
  input ucdc_out_t out_item
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result changed");

  a_one_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.seconds_out != '0) |->
      (out_item.year_out == '0) && (out_item.month_out == '0) &&
      (out_item.day_out == '0) && (out_item.hour_out == '0) &&
      (out_item.minute_out == '0) && (out_item.second_out == '0) &&
      (out_item.weekday_out == '0))
    else $error("make result carries date fields");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.year_out != '0) |->
      (out_item.seconds_out == '0) && (out_item.month_out >= 4'd1) &&
      (out_item.month_out <= 4'd12) && (out_item.day_out >= 5'd1) &&
      (out_item.hour_out <= 5'd23) && (out_item.minute_out <= 6'd59) &&
      (out_item.second_out <= 6'd59) && (out_item.weekday_out <= 3'd6))
    else $error("split result field out of range");

endmodule

bind unix_time_civil_date_convert ucdc_checker u_ucdc_checker (.*);
